FILE: rtl/core/tcw_pkg.sv
package tcw_pkg;

   // Field widths of the stream and register ports
   localparam int ACTION_W    = 2;
   localparam int CHAR_W      = 8;
   localparam int TCOL_W      = 7;
   localparam int TROW_W      = 5;
   localparam int OFFSET_W    = 11;
   localparam int CELL_W      = 16;
   localparam int COLOR_W     = 4;
   localparam int ATTR_W      = 2 * COLOR_W;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 40;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_MOVE  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd3;

   // Character codes
   localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
   localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
   localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;
   localparam logic [CHAR_W-1:0] CODE_BLANK = 8'h20;

   // Color register reset values
   localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
   localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic put_exec;
      logic move_cursor;
      logic home_cursor;
      logic read_cell;
      logic ptr_clear;
      logic scroll_read;
      logic scroll_write;
      logic fill_write;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                need_scroll;
      logic                move_last;
      logic                fill_last;
      logic                rsp_free;
   } status_type;

endpackage

FILE: rtl/core/tcw_csr.sv
module tcw_csr
   import tcw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [ATTR_W-1:0]     attr
);

   logic [COLOR_W-1:0] fg_ff;
   logic [COLOR_W-1:0] bg_ff;
   logic               wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // Color registers: foreground at 0x0, background at 0x4
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else if (wr_en) begin
         if (csr_paddr[2]) begin
            bg_ff <= csr_pwdata[COLOR_W-1:0];
         end else begin
            fg_ff <= csr_pwdata[COLOR_W-1:0];
         end
      end
   end

   // Read back
   assign csr_prdata = csr_paddr[2] ? CSR_DATA_W'(bg_ff) : CSR_DATA_W'(fg_ff);

   // Cell attribute: background in the high nibble
   assign attr = {bg_ff, fg_ff};

endmodule

FILE: rtl/core/tcw_ctrl.sv
module tcw_ctrl
   import tcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_EXEC   = 6'b000010,
      S_SCR_RD = 6'b000100,
      S_SCR_WR = 6'b001000,
      S_FILL   = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            case (status.action)
               ACT_PUT: begin
                  cmd.put_exec = 1'b1;
                  if (status.need_scroll) begin
                     cmd.ptr_clear = 1'b1;
                     state_in      = S_SCR_RD;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               ACT_CLEAR: begin
                  cmd.ptr_clear   = 1'b1;
                  cmd.home_cursor = 1'b1;
                  state_in        = S_FILL;
               end
               ACT_MOVE: begin
                  cmd.move_cursor = 1'b1;
                  state_in        = S_DONE;
               end
               default: begin
                  // read cell: data lands in the read register next cycle
                  cmd.read_cell = 1'b1;
                  state_in      = S_DONE;
               end
            endcase
         end
         S_SCR_RD: begin
            cmd.scroll_read = 1'b1;
            state_in        = S_SCR_WR;
         end
         S_SCR_WR: begin
            cmd.scroll_write = 1'b1;
            if (status.move_last) begin
               state_in = S_FILL;
            end else begin
               state_in = S_SCR_RD;
            end
         end
         S_FILL: begin
            cmd.fill_write = 1'b1;
            if (status.fill_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               req_tready   = 1'b1;
               if (req_tvalid) begin
                  cmd.load_req = 1'b1;
                  state_in     = S_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/tcw_datapath.sv
module tcw_datapath
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  cmd_type                cmd,
   output status_type             status,
   input  logic [ATTR_W-1:0]      attr,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CELLS     = COLUMNS * ROWS;
   localparam int MOVE_LAST = (ROWS - 1) * COLUMNS - 1;
   localparam int CW        = $clog2(COLUMNS);
   localparam int RW        = $clog2(ROWS);
   localparam int AW        = $clog2(CELLS);

   // Latched request
   logic [ACTION_W-1:0] req_action_ff;
   logic [CHAR_W-1:0]   req_code_ff;
   logic [TCOL_W-1:0]   req_col_ff;
   logic [TROW_W-1:0]   req_row_ff;

   // Cursor, sweep pointer, memory
   logic [CW-1:0]     cur_col_ff;
   logic [RW-1:0]     cur_row_ff;
   logic [AW-1:0]     ptr_ff;
   logic [CELL_W-1:0] screen_ff [CELLS];
   logic [CELL_W-1:0] rd_data_ff;

   // Response register
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic [CW-1:0]     tgt_col;
   logic [RW-1:0]     tgt_row;
   logic [AW-1:0]     tgt_addr;
   logic [AW-1:0]     cur_addr;
   logic [CW-1:0]     put_col;
   logic [RW:0]       put_row;
   logic              put_wr;
   logic              put_scroll;
   logic [CELL_W-1:0] blank;
   logic              mem_we;
   logic [AW-1:0]     wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic              mem_re;
   logic [AW-1:0]     rd_addr;
   logic [CELL_W-1:0] cell_out;

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_action_ff <= req_tdata[1:0];
         req_code_ff   <= req_tdata[9:2];
         req_col_ff    <= req_tdata[16:10];
         req_row_ff    <= req_tdata[21:17];
      end
   end

   // Saturate targets to the screen
   assign tgt_col = (8'(req_col_ff) >= 8'(COLUMNS)) ? CW'(COLUMNS - 1) : CW'(req_col_ff);
   assign tgt_row = (7'(req_row_ff) >= 7'(ROWS)) ? RW'(ROWS - 1) : RW'(req_row_ff);

   assign tgt_addr = AW'(tgt_row) * AW'(COLUMNS) + AW'(tgt_col);
   assign cur_addr = AW'(cur_row_ff) * AW'(COLUMNS) + AW'(cur_col_ff);
   assign blank    = {attr, CODE_BLANK};

   // Put character: next cursor, wrap and scroll detect
   always_comb begin
      put_col = cur_col_ff;
      put_row = {1'b0, cur_row_ff};
      put_wr  = 1'b0;
      case (req_code_ff)
         CODE_CR: put_col = '0;
         CODE_LF: put_row = {1'b0, cur_row_ff} + 1'b1;
         CODE_BS: begin
            if (cur_col_ff != '0) begin
               put_col = cur_col_ff - 1'b1;
            end
         end
         default: begin
            if (req_code_ff >= CODE_BLANK) begin
               put_wr = 1'b1;
               if (cur_col_ff == CW'(COLUMNS - 1)) begin
                  put_col = '0;
                  put_row = {1'b0, cur_row_ff} + 1'b1;
               end else begin
                  put_col = cur_col_ff + 1'b1;
               end
            end
         end
      endcase
      put_scroll = (put_row == (RW + 1)'(ROWS));
   end

   // Cursor registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff <= '0;
         cur_row_ff <= '0;
      end else if (cmd.home_cursor) begin
         cur_col_ff <= '0;
         cur_row_ff <= '0;
      end else if (cmd.move_cursor) begin
         cur_col_ff <= tgt_col;
         cur_row_ff <= tgt_row;
      end else if (cmd.put_exec) begin
         cur_col_ff <= put_col;
         cur_row_ff <= put_scroll ? RW'(ROWS - 1) : RW'(put_row);
      end
   end

   // Sweep pointer for scroll and clear
   always_ff @(posedge clock) begin
      if (cmd.ptr_clear) begin
         ptr_ff <= '0;
      end else if (cmd.scroll_write || cmd.fill_write) begin
         ptr_ff <= ptr_ff + 1'b1;
      end
   end

   // Memory port selection
   always_comb begin
      mem_we  = 1'b0;
      wr_addr = ptr_ff;
      wr_data = blank;
      if (cmd.put_exec && put_wr) begin
         mem_we  = 1'b1;
         wr_addr = cur_addr;
         wr_data = {attr, req_code_ff};
      end else if (cmd.scroll_write) begin
         mem_we  = 1'b1;
         wr_data = rd_data_ff;
      end else if (cmd.fill_write) begin
         mem_we = 1'b1;
      end
   end

   assign mem_re  = cmd.read_cell | cmd.scroll_read;
   assign rd_addr = cmd.read_cell ? tgt_addr : ptr_ff + AW'(COLUMNS);

   // Screen memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_ff[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= screen_ff[rd_addr];
      end
   end

   // Response register
   assign cell_out = (req_action_ff == ACT_READ) ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= {1'b0, cell_out, OFFSET_W'(cur_addr), TROW_W'(cur_row_ff),
                         TCOL_W'(cur_col_ff)};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status to controller
   assign status.action      = req_action_ff;
   assign status.need_scroll = put_scroll;
   assign status.move_last   = (ptr_ff == AW'(MOVE_LAST));
   assign status.fill_last   = (ptr_ff == AW'(CELLS - 1));
   assign status.rsp_free    = ~rsp_valid_ff | rsp_tready;

endmodule

FILE: rtl/core/text_console_writer_unit.sv
// Put, move and read requests pass the execute and result-load steps after acceptance;
// a new request is taken in the result-load step while the result register is free.
// A put that scrolls first moves each row up, a read then a write per moved cell, then
// blanks the bottom row; clear screen blanks every cell, one cell write a cycle.
// Reset homes the cursor, sets foreground 15 and background 0; screen contents
// are undefined until written and there is no clearing pass.
module text_console_writer_unit
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                   clock,
   input  logic                   reset,
   // action[1:0], char_code[9:2], target_column[16:10], target_row[21:17]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // cursor_column[6:0], cursor_line[11:7], cursor_offset[22:12], cell_word[38:23]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   cmd_type           cmd;
   status_type        status;
   logic [ATTR_W-1:0] attr;

   // Color registers
   tcw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .attr        (attr)
   );

   // Sequencer
   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Cursor, screen memory and result register
   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .attr       (attr),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: verif/text_console_writer_unit_tb.sv
module text_console_writer_unit_tb;
   import tcw_pkg::*;

   localparam int SCREEN_COLS = 80;
   localparam int SCREEN_ROWS = 25;
   localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
   localparam int REG_FG      = 0;
   localparam int REG_BG      = 1;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 255;
   localparam int HOLD_CYCLES = 400;

   // Request fields, lowest bits last: packs straight into req_tdata
   typedef struct packed {
      logic [TROW_W-1:0]   trow;
      logic [TCOL_W-1:0]   tcol;
      logic [CHAR_W-1:0]   code;
      logic [ACTION_W-1:0] action;
   } console_request_type;

   // Response fields, lowest bits last: unpacks straight from rsp_tdata
   typedef struct packed {
      logic [CELL_W-1:0]   cell_word;
      logic [OFFSET_W-1:0] offset;
      logic [TROW_W-1:0]   line;
      logic [TCOL_W-1:0]   col;
   } cursor_report_type;

   // Shadow copy of the screen and cursor; queues the cursor reports to expect
   class console_shadow_type;
      logic [CELL_W-1:0]  cells [CELL_COUNT];
      int                 col = 0;
      int                 row = 0;
      logic [COLOR_W-1:0] fg = FG_RESET;
      logic [COLOR_W-1:0] bg = BG_RESET;
      cursor_report_type  expected_reports [$];
      int unsigned        mismatch_count = 0;

      function void set_color(int idx, logic [COLOR_W-1:0] value);
         if (idx == REG_FG) begin
            fg = value;
         end else begin
            bg = value;
         end
      endfunction

      function logic [CELL_W-1:0] blank_cell();
         return {bg, fg, CODE_BLANK};
      endfunction

      function void put_code(logic [CHAR_W-1:0] code);
         if (code == CODE_CR) begin
            col = 0;
         end else if (code == CODE_LF) begin
            row++;
         end else if (code == CODE_BS) begin
            if (col > 0) col--;
         end else if (code >= CODE_BLANK) begin
            cells[row * SCREEN_COLS + col] = {bg, fg, code};
            col++;
         end
         // wrap at the last column, scroll past the last row
         if (col >= SCREEN_COLS) begin
            col = 0;
            row++;
         end
         if (row >= SCREEN_ROWS) begin
            for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
               cells[i] = cells[i + SCREEN_COLS];
            for (int i = (SCREEN_ROWS - 1) * SCREEN_COLS; i < CELL_COUNT; i++)
               cells[i] = blank_cell();
            row = SCREEN_ROWS - 1;
         end
      endfunction

      function void note_request(console_request_type r);
         cursor_report_type e;
         int tc;
         int tr;
         tc = (int'(r.tcol) >= SCREEN_COLS) ? SCREEN_COLS - 1 : int'(r.tcol);
         tr = (int'(r.trow) >= SCREEN_ROWS) ? SCREEN_ROWS - 1 : int'(r.trow);
         e.cell_word = '0;
         case (r.action)
            ACT_PUT: put_code(r.code);
            ACT_CLEAR: begin
               for (int i = 0; i < CELL_COUNT; i++) cells[i] = blank_cell();
               col = 0;
               row = 0;
            end
            ACT_MOVE: begin
               col = tc;
               row = tr;
            end
            ACT_READ: e.cell_word = cells[tr * SCREEN_COLS + tc];
         endcase
         e.col    = TCOL_W'(col);
         e.line   = TROW_W'(row);
         e.offset = OFFSET_W'(row * SCREEN_COLS + col);
         expected_reports.push_back(e);
      endfunction

      task flag_mismatch(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatch_count++;
      endtask

      task check_report(cursor_report_type got);
         cursor_report_type e;
         if (expected_reports.size() == 0) begin
            flag_mismatch($sformatf("response with none pending: %h", got));
            return;
         end
         e = expected_reports.pop_front();
         if (got.col !== e.col)
            flag_mismatch($sformatf("cursor_column %0d, want %0d", got.col, e.col));
         if (got.line !== e.line)
            flag_mismatch($sformatf("cursor_line %0d, want %0d", got.line, e.line));
         if (got.offset !== e.offset)
            flag_mismatch($sformatf("cursor_offset %0d, want %0d", got.offset, e.offset));
         if (got.cell_word !== e.cell_word)
            flag_mismatch($sformatf("cell_word %h, want %h", got.cell_word, e.cell_word));
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   // action[1:0], char_code[9:2], target_column[16:10], target_row[21:17]
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tvalid;
   logic                   req_tready;
   // cursor_column[6:0], cursor_line[11:7], cursor_offset[22:12], cell_word[38:23]
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [CSR_ADDR_W-1:0]  csr_paddr;
   logic [CSR_DATA_W-1:0]  csr_pwdata;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   console_shadow_type shadow = new;
   bit                 steady_traffic = 1'b0;
   bit                 receiver_hold = 1'b0;
   int unsigned        requests_sent = 0;

   text_console_writer_unit #(.COLUMNS(SCREEN_COLS), .ROWS(SCREEN_ROWS)) uut (.*);

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Response checking at each accepted transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) shadow.check_report(rsp_tdata[38:0]);
   end

   // Receiver: random stalls, one long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (receiver_hold) begin
            receiver_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= steady_traffic || ($urandom_range(99) >= 7);
      end
   end

   initial begin
      #100_000_000;
      $display("text_console_writer_unit_tb failed");
      $finish;
   end

   task automatic send_request(logic [ACTION_W-1:0] action, logic [CHAR_W-1:0] code,
                               logic [TCOL_W-1:0] tcol, logic [TROW_W-1:0] trow);
      console_request_type r;
      r = '{trow: trow, tcol: tcol, code: code, action: action};
      if (!steady_traffic && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tdata  <= {2'b00, r};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      shadow.note_request(r);
      requests_sent++;
   endtask

   // Stop offering and let every pending response come back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (shadow.expected_reports.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Write a color register, then read it back
   task automatic csr_write(int idx, logic [COLOR_W-1:0] value);
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= CSR_DATA_W'(value);
      csr_pwrite  <= 1'b1;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      shadow.set_color(idx, value);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(value))
         shadow.flag_mismatch($sformatf("register %0d reads %h, want %h",
                                        idx, csr_prdata, value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // One random burst: mostly text runs, some cursor and readback traffic, a little noise
   task automatic send_random_burst();
      int                pick;
      int                sel;
      logic [CHAR_W-1:0] ch;
      pick = $urandom_range(99);
      if (pick < 55) begin
         if ($urandom_range(1) == 1)
            send_request(ACT_MOVE, CHAR_W'($urandom), TCOL_W'($urandom), TROW_W'($urandom));
         repeat ($urandom_range(20, 2)) begin
            sel = $urandom_range(99);
            if (sel < 85) ch = CHAR_W'($urandom_range(255, 32));
            else if (sel < 90) ch = CODE_CR;
            else if (sel < 93) ch = CODE_LF;
            else if (sel < 96) ch = CODE_BS;
            else ch = CHAR_W'($urandom_range(31));
            send_request(ACT_PUT, ch, TCOL_W'($urandom), TROW_W'($urandom));
         end
         // read back the cell left of the cursor, or the cursor cell in column 0
         send_request(ACT_READ, CHAR_W'($urandom),
                      TCOL_W'((shadow.col == 0) ? 0 : shadow.col - 1), TROW_W'(shadow.row));
      end else if (pick < 75) begin
         repeat ($urandom_range(6, 1))
            send_request(ACT_READ, CHAR_W'($urandom), TCOL_W'($urandom), TROW_W'($urandom));
      end else if (pick < 90) begin
         send_request(ACT_MOVE, CHAR_W'($urandom), TCOL_W'($urandom), TROW_W'($urandom));
         send_request(ACT_READ, CHAR_W'($urandom), TCOL_W'($urandom), TROW_W'($urandom));
      end else if (pick < 92) begin
         send_request(ACT_CLEAR, CHAR_W'($urandom), TCOL_W'($urandom), TROW_W'($urandom));
      end else begin
         send_request(ACTION_W'($urandom), CHAR_W'($urandom), TCOL_W'($urandom),
                      TROW_W'($urandom));
      end
   endtask

   initial begin
      logic [COLOR_W-1:0] fg_plan [PHASES];
      logic [COLOR_W-1:0] bg_plan [PHASES];
      int unsigned        phase_start;
      bit                 paused;
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, reset colors; clear first so every read hits a written cell
      send_request(ACT_CLEAR, 8'h00, 7'd0, 5'd0);
      send_request(ACT_READ, 8'h00, 7'd0, 5'd0);
      send_request(ACT_PUT, 8'h41, 7'd0, 5'd0);
      send_request(ACT_PUT, 8'hFF, 7'd0, 5'd0);
      send_request(ACT_PUT, CODE_BLANK, 7'd0, 5'd0);
      send_request(ACT_PUT, 8'h1F, 7'd0, 5'd0);
      send_request(ACT_PUT, 8'h00, 7'd0, 5'd0);
      send_request(ACT_READ, 8'h00, 7'd1, 5'd0);
      // backspace stops at the left edge
      repeat (4) send_request(ACT_PUT, CODE_BS, 7'd0, 5'd0);
      send_request(ACT_MOVE, 8'h00, 7'd10, 5'd2);
      send_request(ACT_PUT, CODE_CR, 7'd0, 5'd0);
      send_request(ACT_PUT, CODE_LF, 7'd0, 5'd0);
      // out-of-range move saturates to the bottom-right corner
      send_request(ACT_MOVE, 8'hFF, 7'd127, 5'd31);
      // last cell: wrap and scroll
      send_request(ACT_PUT, 8'h5A, 7'd0, 5'd0);
      send_request(ACT_READ, 8'h00, 7'd79, 5'd23);
      send_request(ACT_READ, 8'h00, 7'd127, 5'd31);
      // line feed on the bottom row scrolls
      send_request(ACT_PUT, CODE_LF, 7'd0, 5'd0);
      send_request(ACT_READ, 8'h00, 7'd79, 5'd22);
      send_request(ACT_MOVE, 8'h00, 7'd0, 5'd0);
      send_request(ACT_CLEAR, 8'hFF, 7'd127, 5'd31);

      // Random phases, each with its own colors
      fg_plan = '{4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 4'h0};
      bg_plan = '{4'h0, 4'hF, 4'hF, 4'h0, 4'h0, 4'h0};
      for (int p = 4; p < PHASES; p++) begin
         fg_plan[p] = COLOR_W'($urandom);
         bg_plan[p] = COLOR_W'($urandom);
      end
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         csr_write(REG_FG, fg_plan[p]);
         csr_write(REG_BG, bg_plan[p]);
         steady_traffic = (p == 1);
         if (p == 2) receiver_hold = 1'b1;
         paused = 1'b0;
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_ITEMS) begin
            send_random_burst();
            if (p == 3 && !paused && requests_sent - phase_start > PHASE_ITEMS / 2) begin
               paused = 1'b1;
               wait_idle();
            end
         end
      end
      steady_traffic = 1'b0;

      wait_idle();
      repeat (20) @(posedge clock);
      if (shadow.mismatch_count == 0) begin
         $display("text_console_writer_unit_tb passed");
      end else begin
         $display("text_console_writer_unit_tb failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_csr.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_datapath.sv
rtl/core/text_console_writer_unit.sv
verif/text_console_writer_unit_tb.sv
